// ===== hw/rtl/stc_pkg.sv =====
// Shared constants for the sine template correlator: field widths and the
// fixed negative-sine Q1.15 template. No dependencies.
`timescale 1ns / 1ps

package stc_pkg;

    localparam int SAMPLE_W      = 17;
    localparam int COEF_W        = 16;
    localparam int MAG_W         = 16;
    localparam int IN_DATA_W     = 24;   // sample padded to whole bytes
    localparam int OUT_DATA_W    = 16;
    localparam int TEMPLATE_LEN  = 16;
    localparam int TAP_COUNT_DEF = 16;
    localparam int SUM_GROUP     = 8;    // products summed per partial adder

    // round(-sin(2*pi*k/16) * 32768), +1.0 clipped to 32767
    localparam logic signed [COEF_W-1:0] TEMPLATE [TEMPLATE_LEN] = '{
        16'sd0,      -16'sd12540, -16'sd23170, -16'sd30274,
        16'sh8000,   -16'sd30274, -16'sd23170, -16'sd12540,
        16'sd0,       16'sd12540,  16'sd23170,  16'sd30274,
        16'sd32767,   16'sd30274,  16'sd23170,  16'sd12540
    };

endpackage

// ===== hw/rtl/sine_template_correlator.sv =====
// Streaming correlator of a sample frame against a one-period negative-sine
// template, with |sum| / (TAP_COUNT * 2^15) saturated to 16 bits.
// Depends on stc_pkg.
//
//  channel | dir | handshake                     | word
//  --------+-----+-------------------------------+----------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[16:0] sample, tlast last
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata[15:0] magnitude, tlast last
//
// One sample is taken per cycle while s_axis_tready is high; a full window gives one
// result per sample. Seven registers: window, products, partial sums, total, magnitude,
// reciprocal multiply, saturate/output; tvalid is the valid bit of the last.
// A last sample that leaves n samples pending emits n results, one a cycle while the
// output takes them, with s_axis_tready low while the flush shifter is busy.
// Every stage has its own valid bit, so an output stall only backs up full stages.
// Reset (i_rst_n, synchronous, active low) empties the window and the pipeline.
`timescale 1ns / 1ps

module sine_template_correlator
    import stc_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [16:0] sample, [23:17] zero
    input  logic                  s_axis_tlast,   // last_sample

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] magnitude
    output logic                  m_axis_tlast    // last_result
);

    localparam int FW       = $clog2(TAP_COUNT);
    localparam logic [FW-1:0] FILL_TOP = FW'(TAP_COUNT - 1);
    localparam int PW       = SAMPLE_W + COEF_W;
    localparam int NGROUP   = (TAP_COUNT + SUM_GROUP - 1) / SUM_GROUP;
    localparam int GW       = PW + $clog2(SUM_GROUP);
    localparam int SW       = GW + $clog2(NGROUP);
    localparam int MW       = SW - 15;                   // |sum| >> 15
    localparam int SHIFT    = MW + $clog2(TAP_COUNT);
    localparam int PRW      = 2 * MW + 1;
    localparam logic [MW:0] RECIP =
        (MW + 1)'(((64'd1 << SHIFT) + 64'(TAP_COUNT) - 64'd1) / 64'(TAP_COUNT));
    localparam int NSTG     = 7;

    // control
    logic [NSTG-1:0] r_vld, n_vld;
    logic [NSTG-1:0] r_lst;
    logic [NSTG-1:0] w_free;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_rem, n_rem;
    logic            w_in_acc;
    logic            w_emit;
    logic            w_lst0;

    // window of pending samples, zero beyond the fill count
    logic signed [SAMPLE_W-1:0] r_win [TAP_COUNT-1];
    logic signed [SAMPLE_W-1:0] n_win [TAP_COUNT-1];
    logic signed [SAMPLE_W-1:0] w_x;
    logic signed [SAMPLE_W-1:0] w_vec [TAP_COUNT];

    // datapath
    logic signed [SAMPLE_W-1:0] r_vec  [TAP_COUNT];
    logic signed [PW-1:0]       r_prod [TAP_COUNT];
    logic signed [GW-1:0]       w_part [NGROUP];
    logic signed [GW-1:0]       r_part [NGROUP];
    logic signed [SW-1:0]       w_sum;
    logic signed [SW-1:0]       r_sum;
    logic [SW-1:0]              w_abs;
    logic [MW-1:0]              r_mag;
    logic [PRW-1:0]             r_scl;
    logic [MAG_W-1:0]           w_out;
    logic [MAG_W-1:0]           r_out;

    assign w_x = signed'(s_axis_tdata[SAMPLE_W-1:0]);

    // a stage can load when empty or when its word moves on
    always_comb begin
        w_free[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_free[s] = !r_vld[s] || w_free[s+1];
        end
    end

    assign s_axis_tready = w_free[0] && (r_rem == '0);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_emit        = w_in_acc && (s_axis_tlast || r_fill == FILL_TOP);

    always_comb begin
        n_vld[0] = w_free[0] ? ((r_rem != '0) || w_emit) : r_vld[0];
        for (int s = 1; s < NSTG; s++) begin
            n_vld[s] = w_free[s] ? r_vld[s-1] : r_vld[s];
        end
    end

    always_comb begin
        n_rem = r_rem;
        if (w_free[0] && r_rem != '0) begin
            n_rem = r_rem - 1'b1;
        end else if (w_in_acc && s_axis_tlast) begin
            n_rem = r_fill;
        end
    end

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (w_in_acc) begin
            if (s_axis_tlast) begin
                n_win  = '{default: '0};
                n_fill = '0;
            end else if (r_fill == FILL_TOP) begin
                for (int j = 0; j < TAP_COUNT - 2; j++) begin
                    n_win[j] = r_win[j+1];
                end
                n_win[TAP_COUNT-2] = w_x;
            end else begin
                for (int j = 0; j < TAP_COUNT - 1; j++) begin
                    if (r_fill == FW'(j)) begin
                        n_win[j] = w_x;
                    end
                end
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // window with the new sample dropped in at the fill position
    always_comb begin
        for (int j = 0; j < TAP_COUNT - 1; j++) begin
            w_vec[j] = (r_fill == FW'(j)) ? w_x : r_win[j];
        end
        w_vec[TAP_COUNT-1] = (r_fill == FILL_TOP) ? w_x : '0;
    end

    // last flag of the word entering the shifter
    assign w_lst0 = (r_rem != '0) ? (r_rem == FW'(1)) : (s_axis_tlast && (r_fill == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_fill <= '0;
            r_rem  <= '0;
            r_win  <= '{default: '0};
        end else begin
            r_vld  <= n_vld;
            r_fill <= n_fill;
            r_rem  <= n_rem;
            r_win  <= n_win;
        end
    end

    // stage 0: window vector, doubles as the flush shifter
    always_ff @(posedge i_clk) begin
        if (w_free[0]) begin
            if (r_rem != '0) begin
                for (int j = 0; j < TAP_COUNT - 1; j++) begin
                    r_vec[j] <= r_vec[j+1];
                end
                r_vec[TAP_COUNT-1] <= '0;
            end else begin
                r_vec <= w_vec;
            end
        end
    end

    // stage 1: constant-coefficient products
    for (genvar j = 0; j < TAP_COUNT; j++) begin : g_tap
        localparam int K = ((j * TEMPLATE_LEN) / TAP_COUNT) % TEMPLATE_LEN;
        localparam logic signed [COEF_W-1:0] COEF = TEMPLATE[K];
        always_ff @(posedge i_clk) begin
            if (w_free[1]) begin
                r_prod[j] <= PW'(r_vec[j]) * PW'(COEF);
            end
        end
    end

    // stage 2: partial sums of up to eight products
    for (genvar g = 0; g < NGROUP; g++) begin : g_grp
        localparam int NMEM = (TAP_COUNT - g * SUM_GROUP < SUM_GROUP) ?
                              (TAP_COUNT - g * SUM_GROUP) : SUM_GROUP;
        always_comb begin
            w_part[g] = '0;
            for (int k = 0; k < NMEM; k++) begin
                w_part[g] = w_part[g] + GW'(r_prod[g * SUM_GROUP + k]);
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NGROUP; g++) begin
            w_sum = w_sum + SW'(r_part[g]);
        end
    end

    assign w_abs = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    // floor(m / TAP_COUNT) as (m * RECIP) >> SHIFT, exact for m < 2^MW
    assign w_out = (|r_scl[PRW-1:SHIFT+MAG_W]) ? '1 : r_scl[SHIFT+MAG_W-1:SHIFT];

    always_ff @(posedge i_clk) begin
        if (w_free[2]) r_part <= w_part;
        if (w_free[3]) r_sum  <= w_sum;
        if (w_free[4]) r_mag  <= w_abs[SW-1:15];
        if (w_free[5]) r_scl  <= PRW'(r_mag) * PRW'(RECIP);
        if (w_free[6]) r_out  <= w_out;
        if (w_free[0]) r_lst[0] <= w_lst0;
        for (int s = 1; s < NSTG; s++) begin
            if (w_free[s]) r_lst[s] <= r_lst[s-1];
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tlast  = r_lst[NSTG-1];
    assign m_axis_tdata  = r_out;

    // flush in progress implies a word sits in the shifter
    a_flush_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem != '0 |-> r_vld[0])
        else $error("flush count set with empty shifter");

    a_no_take_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem != '0 |-> !s_axis_tready)
        else $error("sample taken during flush");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> (r_fill == '0 && r_vld[0]))
        else $error("last sample did not clear window or start flush");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == '0 |-> r_win[0] == '0)
        else $error("empty window holds stale sample");

endmodule
